>>> rtl/jve_pkg.sv
// Package for the voxel escape-time block: fixed-point widths, grid and escape
// constants, register indexes, controller states and the control/status structs.
// No dependencies.
package jve_pkg;

    localparam int FRAC_BITS      = 28;
    localparam int MAX_RESOLUTION = 256;

    localparam int IDX_W   = 8;
    localparam int RES_W   = 9;
    localparam int CNT_W   = 16;
    localparam int COLOR_W = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_A_W = 2;

    localparam int Q_W    = FRAC_BITS + 4;
    localparam int SQ_W   = 2 * Q_W - FRAC_BITS;
    localparam int AB_W   = SQ_W + 1;
    localparam int SUM_W  = AB_W + 1;
    localparam int NUM_W  = IDX_W + 2;
    localparam int QUO_W  = NUM_W + FRAC_BITS;
    localparam int STEP_W = $clog2(QUO_W);

    localparam logic signed [Q_W-1:0] QMAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] QMIN = {1'b1, {(Q_W-1){1'b0}}};

    localparam logic [QUO_W-1:0] COORD_TOP = QUO_W'(10) << FRAC_BITS;
    localparam logic [QUO_W-1:0] COORD_OFS = QUO_W'(2) << FRAC_BITS;
    localparam logic [SQ_W:0]    ESC_LIM   = (SQ_W+1)'(4) << FRAC_BITS;

    localparam logic [RES_W-1:0] RES_MIN   = RES_W'(2);
    localparam logic [RES_W-1:0] RES_MAX   = RES_W'(MAX_RESOLUTION);
    localparam logic [RES_W-1:0] RES_RST   = RES_W'(256);
    localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(64);
    localparam logic [7:0]       ALPHA     = 8'hFF;

    localparam logic [CFG_A_W-1:0] CFG_GRID_RES   = CFG_A_W'(0);
    localparam logic [CFG_A_W-1:0] CFG_ITER_LIMIT = CFG_A_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_LOAD,
        S_MUL,
        S_UPD,
        S_OUT
    } t_jve_state;

    typedef struct packed {
        logic start;
        logic div_step;
        logic load_coord;
        logic mul;
        logic upd;
        logic load_out;
    } t_jve_cmd;

    typedef struct packed {
        logic esc;
        logic at_limit;
    } t_jve_sts;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &v[SUM_W-1:Q_W-1];
        hi_zeros = ~|v[SUM_W-1:Q_W-1];
        if (hi_ones || hi_zeros) begin
            sat_q = v[Q_W-1:0];
        end else if (v[SUM_W-1]) begin
            sat_q = QMIN;
        end else begin
            sat_q = QMAX;
        end
    endfunction

endpackage

>>> rtl/julia_voxel_escape_time.sv
// Each voxel runs the grid division, then N orbit updates, N being escape_count + 1
// on escape and iteration_limit otherwise; each iteration passes through the squarers
// (multiply, then add and saturate). Voxels are computed one at a time, but a new
// word is taken while the previous result waits in the output register.
// Reset (synchronous, active low): controller idle, no result, registers 256/64.
module julia_voxel_escape_time (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [jve_pkg::CFG_A_W-1:0]   i_cfg_index,
    input  logic [jve_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [jve_pkg::IDX_W-1:0]     i_x_index,
    input  logic [jve_pkg::IDX_W-1:0]     i_y_index,
    input  logic [jve_pkg::IDX_W-1:0]     i_z_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [jve_pkg::CNT_W-1:0]     o_escape_count,
    output logic                          o_inside_set,
    output logic [jve_pkg::COLOR_W-1:0]   o_voxel_color
);
    import jve_pkg::*;

    logic [RES_W-1:0] r_res;
    logic [CNT_W-1:0] r_limit;
    logic [RES_W-1:0] res_eff;
    t_jve_cmd         cmd;
    t_jve_sts         sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res   <= RES_RST;
            r_limit <= LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_RES:   r_res   <= i_cfg_data[RES_W-1:0];
                CFG_ITER_LIMIT: r_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign res_eff = (r_res < RES_MIN) ? RES_MIN :
                     (r_res > RES_MAX) ? RES_MAX : r_res;

    jve_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    jve_datapath u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_res          (res_eff),
        .i_limit        (r_limit),
        .i_x_index      (i_x_index),
        .i_y_index      (i_y_index),
        .i_z_index      (i_z_index),
        .o_escape_count (o_escape_count),
        .o_inside_set   (o_inside_set),
        .o_voxel_color  (o_voxel_color)
    );

`ifndef SYNTHESIS
    a_inside_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_inside_set |-> o_escape_count == r_limit)
        else $error("inside result without count at limit");

    a_escape_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_inside_set |-> o_escape_count < r_limit)
        else $error("escaped result with count not below limit");

    a_escape_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_inside_set |-> o_voxel_color == '0)
        else $error("escaped result with nonzero color");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again right after accept");
`endif

endmodule

>>> rtl/jve_grid_div.sv
// One grid lane: bit-serial restoring division of 4*index*2^F by the resolution,
// then offset to a signed Q4.28 coordinate, clamped to QMAX. Depends on jve_pkg.
module jve_grid_div (
    input  logic                     i_clk,
    input  logic                     i_start,
    input  logic                     i_step,
    input  logic [jve_pkg::IDX_W-1:0] i_index,
    input  logic [jve_pkg::RES_W-1:0] i_res,
    output logic signed [jve_pkg::Q_W-1:0] o_coord
);
    import jve_pkg::*;

    logic [NUM_W-1:0] r_num;
    logic [RES_W-2:0] r_rem;
    logic [QUO_W-1:0] r_quo;

    logic [RES_W-1:0] trial;
    logic [RES_W-1:0] diff;
    logic             ge;
    logic [QUO_W-1:0] ofs;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign ge    = trial >= i_res;
    assign diff  = trial - i_res;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_index, 2'b00};
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_step) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= ge ? diff[RES_W-2:0] : trial[RES_W-2:0];
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    assign ofs     = r_quo - COORD_OFS;
    assign o_coord = (r_quo >= COORD_TOP) ? QMAX : ofs[Q_W-1:0];

endmodule

>>> rtl/jve_datapath.sv
// Datapath: three grid lanes, orbit registers, registered squarer products,
// iteration count and the result register. Depends on jve_pkg and jve_grid_div.
module jve_datapath (
    input  logic                        i_clk,
    input  jve_pkg::t_jve_cmd           i_cmd,
    output jve_pkg::t_jve_sts           o_sts,
    input  logic [jve_pkg::RES_W-1:0]   i_res,
    input  logic [jve_pkg::CNT_W-1:0]   i_limit,
    input  logic [jve_pkg::IDX_W-1:0]   i_x_index,
    input  logic [jve_pkg::IDX_W-1:0]   i_y_index,
    input  logic [jve_pkg::IDX_W-1:0]   i_z_index,
    output logic [jve_pkg::CNT_W-1:0]   o_escape_count,
    output logic                        o_inside_set,
    output logic [jve_pkg::COLOR_W-1:0] o_voxel_color
);
    import jve_pkg::*;

    logic signed [Q_W-1:0] cx;
    logic signed [Q_W-1:0] cy;
    logic signed [Q_W-1:0] cz;

    logic [3:0] r_xn;
    logic [3:0] r_yn;
    logic [3:0] r_zn;

    logic signed [Q_W-1:0]  r_a;
    logic signed [Q_W-1:0]  r_b;
    logic signed [Q_W-1:0]  r_ci;
    logic signed [SQ_W-1:0] r_sa;
    logic signed [SQ_W-1:0] r_sb;
    logic signed [AB_W-1:0] r_ab;
    logic [CNT_W-1:0]       r_k;

    logic [CNT_W-1:0]   r_out_count;
    logic               r_out_inside;
    logic [COLOR_W-1:0] r_out_color;

    logic signed [2*Q_W-1:0] m_aa;
    logic signed [2*Q_W-1:0] m_bb;
    logic signed [2*Q_W-1:0] m_ab;
    logic signed [2*Q_W-1:0] s_aa;
    logic signed [2*Q_W-1:0] s_bb;
    logic signed [2*Q_W-1:0] s_ab;
    logic signed [SUM_W-1:0] re_sum;
    logic signed [SUM_W-1:0] im_sum;
    logic [SQ_W:0]           mag;
    logic                    esc;

    jve_grid_div u_div_x (
        .i_clk   (i_clk),
        .i_start (i_cmd.start),
        .i_step  (i_cmd.div_step),
        .i_index (i_x_index),
        .i_res   (i_res),
        .o_coord (cx)
    );

    jve_grid_div u_div_y (
        .i_clk   (i_clk),
        .i_start (i_cmd.start),
        .i_step  (i_cmd.div_step),
        .i_index (i_y_index),
        .i_res   (i_res),
        .o_coord (cy)
    );

    jve_grid_div u_div_z (
        .i_clk   (i_clk),
        .i_start (i_cmd.start),
        .i_step  (i_cmd.div_step),
        .i_index (i_z_index),
        .i_res   (i_res),
        .o_coord (cz)
    );

    assign m_aa = r_a * r_a;
    assign m_bb = r_b * r_b;
    assign m_ab = r_a * r_b;
    assign s_aa = m_aa >>> FRAC_BITS;
    assign s_bb = m_bb >>> FRAC_BITS;
    assign s_ab = m_ab >>> (FRAC_BITS - 1);

    assign re_sum = SUM_W'(r_sa) - SUM_W'(r_sb);
    assign im_sum = SUM_W'(r_ab) + SUM_W'(r_ci);

    assign mag = {1'b0, r_sa} + {1'b0, r_sb};
    assign esc = (r_k != '0) && (mag > ESC_LIM);

    assign o_sts.esc      = esc;
    assign o_sts.at_limit = (r_k == i_limit);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_xn <= i_x_index[3:0];
            r_yn <= i_y_index[3:0];
            r_zn <= i_z_index[3:0];
        end
        if (i_cmd.load_coord) begin
            r_a  <= cx;
            r_b  <= cy;
            r_ci <= cz;
            r_k  <= '0;
        end else if (i_cmd.upd) begin
            r_a  <= sat_q(re_sum);
            r_b  <= sat_q(im_sum);
            r_k  <= r_k + CNT_W'(1);
        end
        if (i_cmd.mul) begin
            r_sa <= s_aa[SQ_W-1:0];
            r_sb <= s_bb[SQ_W-1:0];
            r_ab <= s_ab[AB_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_out_count  <= esc ? (r_k - CNT_W'(1)) : r_k;
            r_out_inside <= !esc;
            r_out_color  <= esc ? '0
                                : {ALPHA, r_xn, 4'h0, r_yn, 4'h0, r_zn, 4'h0};
        end
    end

    assign o_escape_count = r_out_count;
    assign o_inside_set   = r_out_inside;
    assign o_voxel_color  = r_out_color;

endmodule

>>> rtl/jve_ctrl.sv
// Controller: sequences grid division, the multiply/update iteration loop and
// the result hand-off; owns the channel handshakes. Depends on jve_pkg.
module jve_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  jve_pkg::t_jve_sts i_sts,
    output jve_pkg::t_jve_cmd o_cmd
);
    import jve_pkg::*;

    t_jve_state        r_state;
    t_jve_state        n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_step      = '0;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == STEP_W'(QUO_W - 1)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_coord = 1'b1;
                n_state          = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                if (i_sts.esc || i_sts.at_limit) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_MUL;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> tb/tb_julia_voxel_escape_time.sv
// Self-checking testbench for julia_voxel_escape_time: a directed table, then random
// voxels in phases of grid resolution, iteration limit and handshake idling.
// Depends on rtl/jve_pkg.sv and rtl/julia_voxel_escape_time.sv.
module tb_julia_voxel_escape_time;
    timeunit 1ns;
    timeprecision 1ps;

    import jve_pkg::*;

    localparam int LONG_HOLD = 1500;

    typedef struct packed {
        logic [IDX_W-1:0]   x;
        logic [IDX_W-1:0]   y;
        logic [IDX_W-1:0]   z;
        logic [CNT_W-1:0]   count;
        logic               in_set;
        logic [COLOR_W-1:0] color;
    } t_voxel_expect;

    typedef struct {
        logic [CFG_W-1:0] res_word;
        logic [CFG_W-1:0] limit_word;
        logic [IDX_W-1:0] x;
        logic [IDX_W-1:0] y;
        logic [IDX_W-1:0] z;
        bit               typed;
        logic [CNT_W-1:0] count;
        logic             in_set;
        logic [COLOR_W-1:0] color;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_A_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [IDX_W-1:0]     i_x_index = '0;
    logic [IDX_W-1:0]     i_y_index = '0;
    logic [IDX_W-1:0]     i_z_index = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [CNT_W-1:0]     o_escape_count;
    logic                 o_inside_set;
    logic [COLOR_W-1:0]   o_voxel_color;

    logic [RES_W-1:0]     cur_res = RES_RST;
    logic [CNT_W-1:0]     cur_limit = LIMIT_RST;
    t_voxel_expect        expected_voxels[$];
    t_stim_row            stim_table[$];
    int                   mismatches = 0;
    int                   src_idle_pct = 0;
    int                   sink_stall_pct = 0;
    int                   hold_requests = 0;
    int                   holds_served = 0;
    int                   hold_left = 0;

    julia_voxel_escape_time uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_x_index      (i_x_index),
        .i_y_index      (i_y_index),
        .i_z_index      (i_z_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_escape_count (o_escape_count),
        .o_inside_set   (o_inside_set),
        .o_voxel_color  (o_voxel_color)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic signed [Q_W-1:0] clamp_q(input longint v);
        if (v > longint'(QMAX)) begin
            return QMAX;
        end else if (v < longint'(QMIN)) begin
            return QMIN;
        end
        return v[Q_W-1:0];
    endfunction

    function automatic logic signed [Q_W-1:0] grid_point(input logic [IDX_W-1:0] idx,
                                                         input int res);
        int     num;
        longint scaled;
        num = 4 * int'(idx);
        if (num / res >= 10) begin
            return QMAX;
        end
        scaled = (longint'(num) << FRAC_BITS) / res;
        return clamp_q(scaled - (longint'(2) << FRAC_BITS));
    endfunction

    function automatic t_voxel_expect predict_voxel(input logic [IDX_W-1:0] x,
                                                    input logic [IDX_W-1:0] y,
                                                    input logic [IDX_W-1:0] z);
        t_voxel_expect          e;
        int                     res;
        int                     n;
        bit                     done;
        logic signed [Q_W-1:0]  w_re;
        logic signed [Q_W-1:0]  w_im;
        logic signed [Q_W-1:0]  c_im;
        longint                 sq_re;
        longint                 sq_im;
        res = int'(cur_res);
        if (res < 2) res = 2;
        if (res > MAX_RESOLUTION) res = MAX_RESOLUTION;
        w_re = grid_point(x, res);
        w_im = grid_point(y, res);
        c_im = grid_point(z, res);
        n = 0;
        done = (cur_limit == 0);
        while (!done) begin
            sq_re = (longint'(w_re) * longint'(w_re)) >>> FRAC_BITS;
            sq_im = (longint'(w_im) * longint'(w_im)) >>> FRAC_BITS;
            w_im = clamp_q(((longint'(w_re) * longint'(w_im)) >>> (FRAC_BITS - 1))
                           + longint'(c_im));
            w_re = clamp_q(sq_re - sq_im);
            sq_re = (longint'(w_re) * longint'(w_re)) >>> FRAC_BITS;
            sq_im = (longint'(w_im) * longint'(w_im)) >>> FRAC_BITS;
            if (sq_re + sq_im > (longint'(4) << FRAC_BITS)) begin
                done = 1'b1;
            end else begin
                n++;
                if (n == int'(cur_limit)) done = 1'b1;
            end
        end
        e.x = x;
        e.y = y;
        e.z = z;
        e.count = n[CNT_W-1:0];
        e.in_set = (n == int'(cur_limit));
        e.color = e.in_set ? {ALPHA, x[3:0], 4'h0, y[3:0], 4'h0, z[3:0], 4'h0} : '0;
        return e;
    endfunction

    task automatic add_row(input logic [CFG_W-1:0] res_word, input logic [CFG_W-1:0] lim,
                           input logic [IDX_W-1:0] x, input logic [IDX_W-1:0] y,
                           input logic [IDX_W-1:0] z, input bit typed,
                           input logic [CNT_W-1:0] count, input logic in_set,
                           input logic [COLOR_W-1:0] color);
        t_stim_row r;
        r.res_word = res_word;
        r.limit_word = lim;
        r.x = x;
        r.y = y;
        r.z = z;
        r.typed = typed;
        r.count = count;
        r.in_set = in_set;
        r.color = color;
        stim_table.push_back(r);
    endtask

    // enter and leave at a falling edge
    task automatic send_voxel(input logic [IDX_W-1:0] x, input logic [IDX_W-1:0] y,
                              input logic [IDX_W-1:0] z, input bit typed,
                              input t_voxel_expect want);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_x_index = x;
        i_y_index = y;
        i_z_index = z;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_voxels.push_back(typed ? want : predict_voxel(x, y, z));
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        i_in_valid = 1'b0;
        while (expected_voxels.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] index, input logic [CFG_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_index = index;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (index == CFG_GRID_RES) begin
            cur_res = data[RES_W-1:0];
        end else if (index == CFG_ITER_LIMIT) begin
            cur_limit = data[CNT_W-1:0];
        end
    endtask

    function automatic logic [IDX_W-1:0] pick_index(input int eff, input int kind);
        int span;
        span = eff / 4;
        if (kind == 0) begin
            return IDX_W'($urandom_range(eff - 1));
        end else if (kind == 1) begin
            return IDX_W'(eff / 2 - span + $urandom_range(2 * span));
        end
        return IDX_W'($urandom_range(255));
    endfunction

    always @(negedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_voxel_expect e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_voxels.size() == 0) begin
                $display("%0t: unexpected result, expected none, got count %0d inside %0b color %h",
                         $time, o_escape_count, o_inside_set, o_voxel_color);
                mismatches++;
            end else begin
                e = expected_voxels.pop_front();
                if (o_escape_count !== e.count) begin
                    $display("%0t: voxel (%0d,%0d,%0d) escape_count expected %0d, got %0d",
                             $time, e.x, e.y, e.z, e.count, o_escape_count);
                    mismatches++;
                end
                if (o_inside_set !== e.in_set) begin
                    $display("%0t: voxel (%0d,%0d,%0d) inside_set expected %0b, got %0b",
                             $time, e.x, e.y, e.z, e.in_set, o_inside_set);
                    mismatches++;
                end
                if (o_voxel_color !== e.color) begin
                    $display("%0t: voxel (%0d,%0d,%0d) voxel_color expected %h, got %h",
                             $time, e.x, e.y, e.z, e.color, o_voxel_color);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("tb_julia_voxel_escape_time failed");
        $finish;
    end

    initial begin
        t_voxel_expect    want;
        logic [RES_W-1:0] res9;
        logic [CNT_W-1:0] lim;
        int               eff;
        int               kind;
        int               mode;

        add_row(16'd256, 16'd64, 8'd128, 8'd128, 8'd128, 1, 16'd64, 1'b1, 32'hFF000000);
        add_row(16'd256, 16'd64, 8'd0, 8'd0, 8'd0, 1, 16'd0, 1'b0, 32'h0);
        add_row(16'd256, 16'd64, 8'd255, 8'd255, 8'd255, 1, 16'd0, 1'b0, 32'h0);
        add_row(16'd256, 16'd64, 8'd200, 8'd100, 8'd50, 0, '0, 1'b0, '0);
        add_row(16'd256, 16'd64, 8'd100, 8'd140, 8'd120, 0, '0, 1'b0, '0);
        add_row(16'd256, 16'd64, 8'd64, 8'd150, 8'd90, 0, '0, 1'b0, '0);
        add_row(16'd256, 16'd64, 8'd0, 8'd128, 8'd128, 0, '0, 1'b0, '0);
        add_row(16'd256, 16'd0, 8'h12, 8'h34, 8'h56, 1, 16'd0, 1'b1, 32'hFF204060);
        add_row(16'd256, 16'd0, 8'd255, 8'd0, 8'd255, 1, 16'd0, 1'b1, 32'hFFF000F0);
        add_row(16'd256, 16'd1, 8'd128, 8'd128, 8'd128, 1, 16'd1, 1'b1, 32'hFF000000);
        add_row(16'd256, 16'd65535, 8'd128, 8'd128, 8'd128, 1, 16'd65535, 1'b1, 32'hFF000000);
        add_row(16'd0, 16'd64, 8'd0, 8'd1, 8'd1, 0, '0, 1'b0, '0);
        add_row(16'h0201, 16'd64, 8'd1, 8'd1, 8'd1, 1, 16'd64, 1'b1, 32'hFF101010);
        add_row(16'd2, 16'd64, 8'd2, 8'd2, 8'd2, 0, '0, 1'b0, '0);
        add_row(16'd2, 16'd64, 8'd255, 8'd0, 8'd255, 0, '0, 1'b0, '0);
        add_row(16'd511, 16'd64, 8'd128, 8'd128, 8'd128, 1, 16'd64, 1'b1, 32'hFF000000);
        add_row(16'd257, 16'd64, 8'd255, 8'd255, 8'd255, 0, '0, 1'b0, '0);
        add_row(16'd3, 16'd64, 8'd1, 8'd2, 8'd0, 0, '0, 1'b0, '0);
        add_row(16'd255, 16'd200, 8'd127, 8'd127, 8'd127, 0, '0, 1'b0, '0);
        add_row(16'd100, 16'd1000, 8'd50, 8'd50, 8'd50, 0, '0, 1'b0, '0);
        add_row(16'd100, 16'd1000, 8'd37, 8'd61, 8'd44, 0, '0, 1'b0, '0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (stim_table[i]) begin
            if (stim_table[i].res_word[RES_W-1:0] != cur_res ||
                stim_table[i].limit_word != cur_limit) begin
                wait_all_results();
                write_reg(CFG_GRID_RES, stim_table[i].res_word);
                write_reg(CFG_ITER_LIMIT, stim_table[i].limit_word);
            end
            want.x = stim_table[i].x;
            want.y = stim_table[i].y;
            want.z = stim_table[i].z;
            want.count = stim_table[i].count;
            want.in_set = stim_table[i].in_set;
            want.color = stim_table[i].color;
            send_voxel(stim_table[i].x, stim_table[i].y, stim_table[i].z,
                       stim_table[i].typed, want);
        end

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin
                    res9 = RES_W'(256);
                    lim = CNT_W'(64);
                end
                1: begin
                    res9 = RES_W'(2);
                    lim = CNT_W'($urandom_range(150, 2));
                end
                2: begin
                    res9 = RES_W'($urandom_range(511, 257));
                    lim = '0;
                end
                3: begin
                    res9 = RES_W'($urandom_range(1));
                    lim = CNT_W'(1);
                end
                4: begin
                    res9 = RES_W'(256);
                    lim = CNT_W'($urandom_range(100, 30));
                end
                default: begin
                    res9 = RES_W'($urandom_range(256, 3));
                    lim = CNT_W'($urandom_range(200, 2));
                end
            endcase
            wait_all_results();
            write_reg(CFG_GRID_RES, {7'($urandom_range(127)), res9});
            write_reg(CFG_ITER_LIMIT, lim);

            mode = ph % 4;
            src_idle_pct = (mode == 1) ? 62 : (mode == 3) ? 35 : 0;
            sink_stall_pct = (mode == 2) ? 62 : (mode == 3) ? 35 : 0;
            if (ph == 4) hold_requests++;

            eff = int'(cur_res);
            if (eff < 2) eff = 2;
            if (eff > MAX_RESOLUTION) eff = MAX_RESOLUTION;

            for (int k = 0; k < 95; k++) begin
                kind = $urandom_range(99);
                kind = (kind < 55) ? 0 : (kind < 85) ? 1 : 2;
                if (ph == 5 && k == 47) wait_all_results();
                send_voxel(pick_index(eff, kind), pick_index(eff, kind),
                           pick_index(eff, kind), 0, want);
            end
        end

        wait_all_results();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_julia_voxel_escape_time passed");
        end else begin
            $display("tb_julia_voxel_escape_time failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/jve_pkg.sv
rtl/jve_grid_div.sv
rtl/jve_datapath.sv
rtl/jve_ctrl.sv
rtl/julia_voxel_escape_time.sv
tb/tb_julia_voxel_escape_time.sv
